@@ sv/egcd_pkg.sv @@
// Shared constants for the extended gcd block.
package egcd_pkg;

  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned OPND_W      = DATA_WIDTH - 1;
  localparam int unsigned COEF_W      = DATA_WIDTH;
  localparam int unsigned IN_TDATA_W  = ((2 * OPND_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OPND_W + 2 * COEF_W + 7) / 8) * 8;
  localparam int unsigned CNT_W       = $clog2(OPND_W);

  typedef logic [OPND_W-1:0] opnd_t;
  typedef logic [COEF_W-1:0] coef_t;

endpackage

@@ sv/extended_gcd_top.sv @@
// Extended gcd: gcd(a,b) with Bezout coefficients u, v such that a*u + b*v = gcd.
//
// Input channel s_axis: one beat carries operand_a and operand_b. The block takes a
// beat only while it holds no item in work, so one item is in flight at a time.
// Output channel m_axis: one beat per input beat, carrying gcd_value, coeff_u and
// coeff_v (two's complement).
// Each remainder step has a check state, then a one-bit-per-cycle restoring
// divider over the OPND_W dividend bits, folding each quotient bit into both
// coefficient products on the same pass, then an update state. A remainder
// sequence takes at most 45 steps for 31-bit operands.
// The result sits in an output register; s_axis_tready_o rises again as soon as
// the result is loaded, so the next item is taken while the receiver stalls.
// A finished result waits in its final state only if the output register is
// still full. Reset clears the sequencer and the output valid; no result is lost
// to a stall and none is repeated.
module extended_gcd_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [30:0] operand_a, [61:31] operand_b, upper bits zero
  input  logic [egcd_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [30:0] gcd_value, [62:31] coeff_u, [94:63] coeff_v, upper bits zero
  output logic [egcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [egcd_pkg::CNT_W-1:0] CNT_LAST = egcd_pkg::CNT_W'(egcd_pkg::OPND_W - 1);
  localparam int unsigned PAD_W = egcd_pkg::OUT_TDATA_W - egcd_pkg::OPND_W
                                  - 2 * egcd_pkg::COEF_W;

  logic [2:0]                 state_q, state_d;
  egcd_pkg::opnd_t            rp_q, rp_d, rc_q, rc_d, rem_q, rem_d, dvd_q, dvd_d;
  egcd_pkg::coef_t            up_q, up_d, uc_q, uc_d, vp_q, vp_d, vc_q, vc_d;
  egcd_pkg::coef_t            qu_q, qu_d, qv_q, qv_d;
  logic [egcd_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic                       out_valid_q, out_valid_d;
  egcd_pkg::opnd_t            out_g_q, out_g_d;
  egcd_pkg::coef_t            out_u_q, out_u_d, out_v_q, out_v_d;

  logic [egcd_pkg::OPND_W:0]  rem2, diff;
  logic                       ge;
  logic                       s_beat, load_out;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);

  // restoring divider bit: shift in next dividend bit, subtract if it fits
  assign rem2 = {rem_q, dvd_q[egcd_pkg::OPND_W-1]};
  assign diff = rem2 - {1'b0, rc_q};
  assign ge   = (rem2 >= {1'b0, rc_q});

  always_comb begin
    state_d = state_q;
    rp_d    = rp_q;
    rc_d    = rc_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    up_d    = up_q;
    uc_d    = uc_q;
    vp_d    = vp_q;
    vc_d    = vc_q;
    qu_d    = qu_q;
    qv_d    = qv_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_beat) begin
          rp_d    = s_axis_tdata_i[egcd_pkg::OPND_W-1:0];
          rc_d    = s_axis_tdata_i[2*egcd_pkg::OPND_W-1:egcd_pkg::OPND_W];
          up_d    = egcd_pkg::COEF_W'(1);
          uc_d    = '0;
          vp_d    = '0;
          vc_d    = egcd_pkg::COEF_W'(1);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rc_q == '0) begin
          state_d = ST_FIN;
        end else begin
          rem_d   = '0;
          dvd_d   = rp_q;
          qu_d    = '0;
          qv_d    = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? diff[egcd_pkg::OPND_W-1:0] : rem2[egcd_pkg::OPND_W-1:0];
        dvd_d = {dvd_q[egcd_pkg::OPND_W-2:0], 1'b0};
        // Horner accumulation of q*u and q*v, MSB-first quotient bits
        qu_d  = {qu_q[egcd_pkg::COEF_W-2:0], 1'b0} + (ge ? uc_q : '0);
        qv_d  = {qv_q[egcd_pkg::COEF_W-2:0], 1'b0} + (ge ? vc_q : '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        up_d    = uc_q;
        uc_d    = up_q - qu_q;
        vp_d    = vc_q;
        vc_d    = vp_q - qv_q;
        rp_d    = rc_q;
        rc_d    = rem_q;
        state_d = ST_CHECK;
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_g_d     = out_g_q;
    out_u_d     = out_u_q;
    out_v_d     = out_v_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_g_d     = rp_q;
      out_u_d     = up_q;
      out_v_d     = vp_q;
    end else if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q    <= rp_d;
    rc_q    <= rc_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    up_q    <= up_d;
    uc_q    <= uc_d;
    vp_q    <= vp_d;
    vc_q    <= vc_d;
    qu_q    <= qu_d;
    qv_q    <= qv_d;
    out_g_q <= out_g_d;
    out_u_q <= out_u_d;
    out_v_q <= out_v_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_v_q, out_u_q, out_g_q};

endmodule

@@ sv/egcd_checker.sv @@
// Port-level checks for the extended gcd block, bound to the top level.
module egcd_sva (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [egcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned U_LO = egcd_pkg::OPND_W;
  localparam int unsigned V_LO = egcd_pkg::OPND_W + egcd_pkg::COEF_W;

  logic s_beat;
  logic out_zero;

  assign s_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_zero = (m_axis_tdata_o[egcd_pkg::OPND_W-1:0] == '0);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // one item in flight: no input taken right after a beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // a new result frees the input side in the same cycle
  a_free_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input not ready when result appeared");

  // gcd of zero only from two zero operands: u = 1, v = 0
  a_zero_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_zero |->
      m_axis_tdata_o[V_LO-1:U_LO] == egcd_pkg::COEF_W'(1) &&
      m_axis_tdata_o[V_LO+egcd_pkg::COEF_W-1:V_LO] == '0)
    else $error("zero gcd with wrong coefficients");

endmodule

bind extended_gcd_top egcd_sva u_egcd_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ verif/egcd_checker.sv @@
// Scoreboard for the extended gcd block: predicts gcd and Bezout pair per input beat.
module egcd_checker
  import egcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int                     fail_count_o,
  output int                     outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    opnd_t gcd;
    coef_t u;
    coef_t v;
  } bezout_t;

  bezout_t bezout_q[$];
  bezout_t want;
  bezout_t got;

  // Remainder sequence with coefficient pairs starting at (1,0) and (0,1);
  // arithmetic wraps in 64 bits and is truncated to the port widths.
  function automatic bezout_t bezout_of(input opnd_t a, input opnd_t b);
    longint unsigned r_old, r_new, quot, rem, u_old, u_new, v_old, v_new, tmp;
    bezout_t res;
    r_old = a;
    r_new = b;
    u_old = 1;
    u_new = 0;
    v_old = 0;
    v_new = 1;
    while (r_new != 0) begin
      quot  = r_old / r_new;
      rem   = r_old % r_new;
      tmp   = u_old - quot * u_new;
      u_old = u_new;
      u_new = tmp;
      tmp   = v_old - quot * v_new;
      v_old = v_new;
      v_new = tmp;
      r_old = r_new;
      r_new = rem;
    end
    res.gcd = opnd_t'(r_old);
    res.u   = coef_t'(u_old);
    res.v   = coef_t'(v_old);
    return res;
  endfunction

  // both counts start at zero as int variables
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bezout_q.delete();
      outstanding_o <= 0;
    end else begin
      // result side first: with one item in flight an output beat never
      // belongs to an input beat taken at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.gcd = m_axis_tdata_i[OPND_W-1:0];
        got.u   = m_axis_tdata_i[OPND_W +: COEF_W];
        got.v   = m_axis_tdata_i[OPND_W+COEF_W +: COEF_W];
        if (bezout_q.size() == 0) begin
          $error("unexpected result beat: gcd_value %0d coeff_u %0d coeff_v %0d",
                 got.gcd, $signed(got.u), $signed(got.v));
          fail_count_o = fail_count_o + 1;
        end else begin
          want = bezout_q.pop_front();
          if (got.gcd !== want.gcd) begin
            $error("gcd_value: expected %0d, actual %0d", want.gcd, got.gcd);
            fail_count_o = fail_count_o + 1;
          end
          if (got.u !== want.u) begin
            $error("coeff_u: expected %0d, actual %0d", $signed(want.u), $signed(got.u));
            fail_count_o = fail_count_o + 1;
          end
          if (got.v !== want.v) begin
            $error("coeff_v: expected %0d, actual %0d", $signed(want.v), $signed(got.v));
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        bezout_q.push_back(bezout_of(s_axis_tdata_i[OPND_W-1:0],
                                     s_axis_tdata_i[OPND_W +: OPND_W]));
      end
      outstanding_o <= bezout_q.size();
    end
  end

endmodule

@@ verif/tb_extended_gcd_top.sv @@
// Testbench top for extended_gcd_top: stimulus, flow control phases and verdict.
module tb_extended_gcd_top;
  timeunit 1ns;
  timeprecision 1ps;
  import egcd_pkg::*;

  localparam opnd_t OPND_MAX = '1;
  localparam opnd_t FIB_46   = 31'd1836311903;
  localparam opnd_t FIB_45   = 31'd1134903170;
  localparam int    LATENCY  = 1600;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int snk_hold_cycles = 0;

  extended_gcd_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  egcd_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off counted down here.
  initial begin
    forever begin
      @(negedge clk_i);
      if (snk_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        snk_hold_cycles = snk_hold_cycles - 1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_pair(input opnd_t a, input opnd_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_TDATA_W - 2*OPND_W){1'b0}}, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    longint unsigned a, b, g, f0, f1, tmp;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = $urandom >> 1;
          b = $urandom >> 1;
        end
        3: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        4: begin
          // shared factor so the gcd is not trivially 1
          g = $urandom_range(2, 1 << 16);
          a = g * $urandom_range(0, int'(OPND_MAX / g));
          b = g * $urandom_range(0, int'(OPND_MAX / g));
        end
        5: begin
          a = $urandom >> 1;
          b = 0;
        end
        6: begin
          b = $urandom_range(1, 1 << 20);
          a = b * $urandom_range(1, int'(OPND_MAX / b));
        end
        7: begin
          // consecutive Fibonacci numbers give the longest remainder chains
          f0 = 0;
          f1 = 1;
          repeat ($urandom_range(1, 45)) begin
            tmp = f0 + f1;
            f0  = f1;
            f1  = tmp;
          end
          a = f1;
          b = f0;
        end
        8: begin
          a = $urandom >> $urandom_range(1, 31);
          b = $urandom >> $urandom_range(1, 31);
        end
        default: begin
          a = OPND_MAX - $urandom_range(0, 1000);
          b = OPND_MAX - $urandom_range(0, 1000);
        end
      endcase
      if ($urandom_range(1)) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      send_pair(opnd_t'(a), opnd_t'(b));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero operands, extremes, longest chain, bit patterns
    send_pair(0, 0);
    send_pair(31'd12345, 0);
    send_pair(0, 31'd6789);
    send_pair(OPND_MAX, 0);
    send_pair(0, OPND_MAX);
    send_pair(OPND_MAX, OPND_MAX);
    send_pair(OPND_MAX, OPND_MAX - 1);
    send_pair(OPND_MAX - 1, OPND_MAX);
    send_pair(1, 1);
    send_pair(1, OPND_MAX);
    send_pair(OPND_MAX, 1);
    send_pair(FIB_46, FIB_45);
    send_pair(FIB_45, FIB_46);
    send_pair(31'd240, 31'd46);
    send_pair(31'd12, 31'd18);
    send_pair(31'h5555_5555, 31'h2AAA_AAAA);
    send_pair(31'h4000_0000, 31'h2000_0000);
    send_pair(31'd1000000, 31'd10);
    send_pair(OPND_MAX, 31'h3FFF_FFFF);
    send_pair(31'd7, 31'd7);

    send_random(80);
    drain();

    // receiver holds off long enough for the block to fill and stall its input
    snk_hold_cycles = 4 * LATENCY;
    send_random(4);
    drain();

    src_idle_pct = 74;
    send_random(85);
    drain();

    src_idle_pct  = 0;
    snk_stall_pct = 74;
    send_random(85);
    drain();

    src_idle_pct  = 17;
    snk_stall_pct = 17;
    send_random(85);

    drain();
    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ extended_gcd_top.f @@
sv/egcd_pkg.sv
sv/extended_gcd_top.sv
sv/egcd_checker.sv
verif/egcd_checker.sv
verif/tb_extended_gcd_top.sv
